@@ rtl/bmg_pkg.sv @@
// ----------------------------------------------------------------------------
// Brush mask generator package
// Shared types and constants of the radial brush falloff mask pipeline.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int unsigned MAX_BRUSH_SIZE = 128;

  localparam logic [7:0] CFG_BRUSH_SIZE = 8'd0;
  localparam logic [7:0] CFG_HARDNESS   = 8'd1;
  localparam logic [7:0] CFG_COS_FREQ_X = 8'd2;
  localparam logic [7:0] CFG_COS_FREQ_Y = 8'd3;

  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [30:0] PI_HALF_Q30    = 31'd1686629713;

  localparam logic [6:0] COS_DIV [1:5] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
  localparam logic [6:0] SIN_DIV [1:5] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
  localparam logic [31:0] COS_RCP [1:5] = '{32'd2147483648, 32'd357913941,
                                           32'd143165576, 32'd76695844, 32'd47721858};
  localparam logic [31:0] SIN_RCP [1:5] = '{32'd715827882, 32'd214748364,
                                           32'd102261126, 32'd59652323, 32'd39045157};

  typedef enum logic [1:0] {FO_FULL, FO_ZERO, FO_DIV} falloff_t;
  typedef enum logic [1:0] {QD_0, QD_90, QD_180, QD_270} quad_t;

  typedef struct packed {
    logic [27:0] rem;
    logic [24:0] root;
    logic [17:0] xs;
  } sq_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [24:0] nq;
  } rd_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [30:0] nq;
  } ad_t;

  typedef struct packed {
    falloff_t    kind;
    logic [16:0] rem;
    logic [15:0] q;
  } fd_t;

  typedef struct packed {
    quad_t       quad;
    logic        neg;
    logic [29:0] val;
  } tw_t;

  typedef struct packed {
    quad_t              quad;
    logic               neg;
    logic [29:0]        x2;
    logic [30:0]        ct;
    logic [30:0]        st;
    logic [30:0]        tc;
    logic [30:0]        ts;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } cv_t;

endpackage

@@ rtl/brush_mask_generator.sv @@
// ----------------------------------------------------------------------------
// Brush mask generator
// Radial falloff times cosine modulation, one mask sample per pixel request.
// ----------------------------------------------------------------------------
// One pixel request enters per clock while in_ready is high; the latency is
// set by the bit-per-stage square root (25 stages), the radius divider (25),
// the falloff divider (16) and, in parallel, the angle dividers (31) feeding
// the cosine series. A stalled output holds the whole pipeline, except that
// an empty last stage still lets new requests in.
module brush_mask_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_pix_col,
  input  logic [6:0]  in_pix_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_mask_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import bmg_pkg::*;

  localparam int SQ0 = 1;
  localparam int SQ1 = 25;
  localparam int RD0 = 26;
  localparam int RD1 = 50;
  localparam int FO  = 51;
  localparam int FD1 = 67;
  localparam int VS  = 68;
  localparam int MS  = 69;
  localparam int AD1 = 31;
  localparam int PH  = 32;
  localparam int QM  = 33;
  localparam int XS  = 34;
  localparam int X2  = 35;
  localparam int CSE = 50;
  localparam int CV0 = 51;
  localparam int CV1 = 68;

  logic [7:0]  brush_size_r;
  logic [16:0] hardness_r;
  logic [15:0] cos_freq_x_r;
  logic [15:0] cos_freq_y_r;

  logic [7:0]  s_eff;
  logic [16:0] den;
  logic        en;
  logic        out_load;

  logic        vld_r [0:MS];
  logic [16:0] dsq_r;
  logic [30:0] num_r [2];
  sq_t         sq_r [SQ0:SQ1];
  rd_t         rd_r [RD0:RD1];
  fd_t         fd_r [FO:FD1];
  logic [16:0] v_r;
  ad_t         ad_r [2][1:AD1];
  logic [31:0] ph_r [2];
  tw_t         qm_r [2];
  tw_t         xs_r [2];
  cs_t         cs_r [2][X2:CSE];
  cv_t         cv_r [2][CV0:CV1];
  logic [16:0] m1_r;
  logic [30:0] cym_r;
  logic        dif_r;
  logic        out_valid_r;
  logic [15:0] out_mask_r;

  function automatic sq_t sq_step(sq_t a);
    logic [27:0] rm;
    logic [27:0] tr;
    sq_t         b;
    rm   = {a.rem[25:0], a.xs[17:16]};
    tr   = {1'b0, a.root, 2'b01};
    b.xs = {a.xs[15:0], 2'b00};
    if (rm >= tr) begin
      b.rem  = rm - tr;
      b.root = {a.root[23:0], 1'b1};
    end else begin
      b.rem  = rm;
      b.root = {a.root[23:0], 1'b0};
    end
    return b;
  endfunction

  function automatic rd_t rd_step(rd_t a, logic [7:0] d);
    logic [8:0] t;
    rd_t        b;
    t    = {a.rem, a.nq[24]};
    b.nq = {a.nq[23:0], 1'b0};
    if (t >= {1'b0, d}) begin
      b.rem   = 8'(t - {1'b0, d});
      b.nq[0] = 1'b1;
    end else begin
      b.rem = t[7:0];
    end
    return b;
  endfunction

  function automatic ad_t ad_step(ad_t a, logic [7:0] d);
    logic [8:0] t;
    ad_t        b;
    t    = {a.rem, a.nq[30]};
    b.nq = {a.nq[29:0], 1'b0};
    if (t >= {1'b0, d}) begin
      b.rem   = 8'(t - {1'b0, d});
      b.nq[0] = 1'b1;
    end else begin
      b.rem = t[7:0];
    end
    return b;
  endfunction

  function automatic fd_t fd_step(fd_t a, logic [16:0] d);
    logic [17:0] t;
    fd_t         b;
    t      = {a.rem, 1'b0};
    b.kind = a.kind;
    if (t >= {1'b0, d}) begin
      b.rem = 17'(t - {1'b0, d});
      b.q   = {a.q[14:0], 1'b1};
    end else begin
      b.rem = t[16:0];
      b.q   = {a.q[14:0], 1'b0};
    end
    return b;
  endfunction

  function automatic cs_t cs_mul(cs_t a);
    logic [60:0] pc;
    logic [60:0] ps;
    cs_t         b;
    b    = a;
    pc   = a.ct * a.x2;
    ps   = a.st * a.x2;
    b.ct = pc[60:30];
    b.st = ps[60:30];
    return b;
  endfunction

  function automatic cs_t cs_rcp(cs_t a, logic [31:0] mc, logic [31:0] ms);
    logic [62:0] pc;
    logic [62:0] ps;
    cs_t         b;
    b    = a;
    pc   = a.ct * mc;
    ps   = a.st * ms;
    b.tc = a.ct;
    b.ts = a.st;
    b.ct = pc[62:32];
    b.st = ps[62:32];
    return b;
  endfunction

  function automatic cs_t cs_fix(cs_t a, logic [6:0] dc, logic [6:0] ds, logic sub);
    logic [37:0] pc;
    logic [37:0] ps;
    logic [30:0] rc;
    logic [30:0] rs;
    logic [30:0] qc;
    logic [30:0] qs;
    cs_t         b;
    b  = a;
    pc = a.ct * dc;
    ps = a.st * ds;
    rc = a.tc - pc[30:0];
    rs = a.ts - ps[30:0];
    qc = (rc >= {24'd0, dc}) ? a.ct + 31'd1 : a.ct;
    qs = (rs >= {24'd0, ds}) ? a.st + 31'd1 : a.st;
    b.ct = qc;
    b.st = qs;
    if (sub) begin
      b.c = a.c - $signed({1'b0, qc});
      b.s = a.s - $signed({1'b0, qs});
    end else begin
      b.c = a.c + $signed({1'b0, qc});
      b.s = a.s + $signed({1'b0, qs});
    end
    return b;
  endfunction

  function automatic logic [15:0] fabs16(logic [15:0] f);
    logic [16:0] t;
    t = f[15] ? 17'h10000 - {1'b0, f} : {1'b0, f};
    return t[15:0];
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brush_size_r <= 8'd40;
      hardness_r   <= 17'd0;
      cos_freq_x_r <= 16'd0;
      cos_freq_y_r <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BRUSH_SIZE: brush_size_r <= cfg_data[7:0];
        CFG_HARDNESS:   hardness_r   <= cfg_data;
        CFG_COS_FREQ_X: cos_freq_x_r <= cfg_data[15:0];
        CFG_COS_FREQ_Y: cos_freq_y_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (brush_size_r == 8'd0) begin
      s_eff = 8'd1;
    end else if (32'(brush_size_r) > MAX_BRUSH_SIZE) begin
      s_eff = 8'(MAX_BRUSH_SIZE);
    end else begin
      s_eff = brush_size_r;
    end
    den = 17'h10000 - hardness_r;
  end

  // flow control
  assign out_load  = !out_valid_r || out_ready;
  assign en        = out_load || !vld_r[MS];
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_mask_value = out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= MS; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r[0] <= in_valid;
        for (int k = 1; k <= MS; k++) vld_r[k] <= vld_r[k-1];
      end
      if (out_load) out_valid_r <= vld_r[MS];
    end
  end

  // stage 0: centered coordinates
  logic signed [9:0] nx;
  logic signed [9:0] ny;
  logic [9:0]        nxa;
  logic [9:0]        nya;
  logic [15:0]       sqx;
  logic [15:0]       sqy;
  logic [23:0]       prx;
  logic [23:0]       pry;

  always_comb begin
    nx  = $signed({2'b00, in_pix_col, 1'b1}) - $signed({2'b00, s_eff});
    ny  = $signed({2'b00, in_pix_row, 1'b1}) - $signed({2'b00, s_eff});
    nxa = nx[9] ? 10'(-nx) : nx;
    nya = ny[9] ? 10'(-ny) : ny;
    sqx = nxa[7:0] * nxa[7:0];
    sqy = nya[7:0] * nya[7:0];
    prx = nxa[7:0] * fabs16(cos_freq_x_r);
    pry = nya[7:0] * fabs16(cos_freq_y_r);
  end

  // falloff and cosine select helpers
  logic [24:0] r_q;
  logic [24:0] diff;
  fd_t         fo_nxt;
  cv_t         cv_nxt [2];

  always_comb begin
    r_q  = rd_r[RD1].nq;
    diff = r_q - {8'd0, hardness_r};
    fo_nxt.rem = diff[16:0];
    fo_nxt.q   = 16'd0;
    if (r_q < {8'd0, hardness_r}) begin
      fo_nxt.kind = FO_FULL;
    end else if (hardness_r[16] || diff >= {8'd0, den}) begin
      fo_nxt.kind = FO_ZERO;
    end else begin
      fo_nxt.kind = FO_DIV;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_sel
    logic signed [31:0] ss;
    logic signed [31:0] val;
    always_comb begin
      ss = cs_r[a][CSE].neg ? -cs_r[a][CSE].s : cs_r[a][CSE].s;
      case (cs_r[a][CSE].quad)
        QD_0:    val = cs_r[a][CSE].c;
        QD_90:   val = -ss;
        QD_180:  val = -cs_r[a][CSE].c;
        default: val = ss;
      endcase
      cv_nxt[a].neg = val[31];
      cv_nxt[a].mag = val[31] ? 31'(-val) : val[30:0];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [31:0] phs [2];
    logic [60:0] php [2];
    logic [31:0] dd  [2];
    logic [31:0] mg  [2];
    logic [60:0] xp  [2];
    logic [59:0] x2p [2];
    logic [47:0] mp1;
    logic [47:0] mp2;
    sq_t         sq0;
    rd_t         rd0;
    ad_t         ad0;
    if (en) begin
      dsq_r    <= 17'(sqx) + 17'(sqy);
      num_r[0] <= {prx[22:0], 8'h00};
      num_r[1] <= {pry[22:0], 8'h00};

      sq0.rem  = 28'd0;
      sq0.root = 25'd0;
      sq0.xs   = {1'b0, dsq_r};
      sq_r[SQ0] <= sq_step(sq0);
      for (int k = SQ0 + 1; k <= SQ1; k++) sq_r[k] <= sq_step(sq_r[k-1]);

      rd0.rem = 8'd0;
      rd0.nq  = sq_r[SQ1].root;
      rd_r[RD0] <= rd_step(rd0, s_eff);
      for (int k = RD0 + 1; k <= RD1; k++) rd_r[k] <= rd_step(rd_r[k-1], s_eff);

      fd_r[FO] <= fo_nxt;
      for (int k = FO + 1; k <= FD1; k++) fd_r[k] <= fd_step(fd_r[k-1], den);

      case (fd_r[FD1].kind)
        FO_FULL: v_r <= 17'h10000;
        FO_DIV:  v_r <= 17'h10000 - {1'b0, fd_r[FD1].q};
        default: v_r <= 17'd0;
      endcase

      for (int a = 0; a < 2; a++) begin
        ad0.rem = 8'd0;
        ad0.nq  = num_r[a];
        ad_r[a][1] <= ad_step(ad0, s_eff);
        for (int k = 2; k <= AD1; k++) ad_r[a][k] <= ad_step(ad_r[a][k-1], s_eff);

        php[a] = ad_r[a][AD1].nq * INV_TWO_PI_Q32;
        ph_r[a] <= php[a][47:16];

        phs[a] = ph_r[a] + 32'h2000_0000;
        dd[a]  = ph_r[a] - {phs[a][31:30], 30'd0};
        mg[a]  = dd[a][31] ? -dd[a] : dd[a];
        qm_r[a].quad <= quad_t'(phs[a][31:30]);
        qm_r[a].neg  <= dd[a][31];
        qm_r[a].val  <= mg[a][29:0];

        xp[a] = qm_r[a].val * PI_HALF_Q30;
        xs_r[a].quad <= qm_r[a].quad;
        xs_r[a].neg  <= qm_r[a].neg;
        xs_r[a].val  <= xp[a][59:30];

        x2p[a] = xs_r[a].val * xs_r[a].val;
        cs_r[a][X2].quad <= xs_r[a].quad;
        cs_r[a][X2].neg  <= xs_r[a].neg;
        cs_r[a][X2].x2   <= x2p[a][59:30];
        cs_r[a][X2].ct   <= 31'h4000_0000;
        cs_r[a][X2].st   <= {1'b0, xs_r[a].val};
        cs_r[a][X2].tc   <= 31'd0;
        cs_r[a][X2].ts   <= 31'd0;
        cs_r[a][X2].c    <= 32'sh4000_0000;
        cs_r[a][X2].s    <= $signed({2'b00, xs_r[a].val});

        for (int j = 0; j < 5; j++) begin
          cs_r[a][X2+1+3*j] <= cs_mul(cs_r[a][X2+3*j]);
          cs_r[a][X2+2+3*j] <= cs_rcp(cs_r[a][X2+1+3*j], COS_RCP[j+1], SIN_RCP[j+1]);
          cs_r[a][X2+3+3*j] <= cs_fix(cs_r[a][X2+2+3*j], COS_DIV[j+1], SIN_DIV[j+1],
                                      !j[0]);
        end

        cv_r[a][CV0] <= cv_nxt[a];
        for (int k = CV0 + 1; k <= CV1; k++) cv_r[a][k] <= cv_r[a][k-1];
      end

      mp1 = v_r * cv_r[0][CV1].mag;
      m1_r  <= mp1[46:30];
      cym_r <= cv_r[1][CV1].mag;
      dif_r <= cv_r[0][CV1].neg != cv_r[1][CV1].neg;
    end

    if (out_load) begin
      mp2 = m1_r * cym_r;
      if (dif_r) begin
        out_mask_r <= 16'h0000;
      end else if (mp2[46]) begin
        out_mask_r <= 16'hFFFF;
      end else begin
        out_mask_r <= mp2[45:30];
      end
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && vld_r[MS]))
    else $error("input blocked without a stalled result");

  a_radius_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[RD1]) |-> (rd_r[RD1].rem < s_eff))
    else $error("radius divider remainder out of range");

  a_falloff_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[FD1] && fd_r[FD1].kind == FO_DIV) |-> (fd_r[FD1].rem < den))
    else $error("falloff divider remainder out of range");

  a_sign_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && vld_r[MS] && dif_r) |=> (out_mask_value == 16'h0000))
    else $error("opposite cosine signs must give zero");

endmodule

@@ tb/brush_mask_generator_tb.sv @@
// ----------------------------------------------------------------------------
// Brush mask generator testbench
// Drives pixel requests and register writes into the mask pipeline under
// random idling on both sides, predicts every mask value with a bit-exact
// fixed-point model and checks results in order through a scoreboard.
// ----------------------------------------------------------------------------
module brush_mask_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmg_pkg::*;

  localparam int LATENCY = 71;

  class mask_scoreboard;
    bit [31:0] size_reg, hard_reg, fx_reg, fy_reg;
    logic [15:0] pending_masks[$];
    int errors;

    function new();
      size_reg = 40;
      hard_reg = 0;
      fx_reg = 0;
      fy_reg = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [16:0] data);
      case (idx)
        CFG_BRUSH_SIZE: size_reg = 32'(data[7:0]);
        CFG_HARDNESS:   hard_reg = 32'(data);
        CFG_COS_FREQ_X: fx_reg = 32'(data[15:0]);
        CFG_COS_FREQ_Y: fy_reg = 32'(data[15:0]);
        default: ;
      endcase
    endfunction

    function longint unsigned root64(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint cos_phase(bit [31:0] p);
      bit [31:0] q, d;
      bit neg;
      longint unsigned mag, x, x2, ct, st;
      longint c, s, ss;
      q = ((p + 32'h2000_0000) >> 30) & 3;
      d = p - (q << 30);
      neg = d[31];
      mag = neg ? 64'(32'(0 - d)) : 64'(d);
      x = (mag * 1686629713) >> 30;
      x2 = (x * x) >> 30;
      ct = 64'd1 << 30;
      st = x;
      c = ct;
      s = st;
      for (int k = 1; k <= 5; k++) begin
        ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2) begin
          c -= ct;
          s -= st;
        end else begin
          c += ct;
          s += st;
        end
      end
      ss = neg ? -s : s;
      case (q)
        0: return c;
        1: return -ss;
        2: return -c;
        default: return ss;
      endcase
    endfunction

    function longint axis_cosine(longint n, bit [31:0] freq, longint unsigned sz);
      longint unsigned nm, fm, a;
      bit [15:0] f;
      f = freq[15:0];
      fm = f[15] ? 64'(17'h10000 - f) : 64'(f);
      nm = n < 0 ? -n : n;
      a = (nm * fm * 256) / sz;
      return cos_phase(32'((a * 683565276) >> 16));
    endfunction

    function void note_request(logic [6:0] col, logic [6:0] row);
      longint unsigned sz, r, h, v, m, cxm, cym, q;
      longint nx, ny, cx, cy;
      sz = 64'(size_reg);
      if (sz == 0) sz = 1;
      if (sz > MAX_BRUSH_SIZE) sz = MAX_BRUSH_SIZE;
      nx = 2 * longint'(col) + 1 - longint'(sz);
      ny = 2 * longint'(row) + 1 - longint'(sz);
      r = root64(64'(nx * nx + ny * ny) << 32) / sz;
      h = 64'(hard_reg);
      if (r < h) v = 65536;
      else if (h >= 65536) v = 0;
      else begin
        q = ((r - h) << 16) / (65536 - h);
        v = (q >= 65536) ? 0 : 65536 - q;
      end
      cx = axis_cosine(nx, fx_reg, sz);
      cy = axis_cosine(ny, fy_reg, sz);
      cxm = cx < 0 ? -cx : cx;
      cym = cy < 0 ? -cy : cy;
      m = (((v * cxm) >> 30) * cym) >> 30;
      if ((cx < 0) != (cy < 0)) m = 0;
      if (m > 65535) m = 65535;
      pending_masks = {pending_masks, m[15:0]};
    endfunction

    function void check_mask(logic [15:0] got);
      logic [15:0] exp_mask;
      if (pending_masks.size() == 0) begin
        $display("%0t: unexpected mask value %0d", $time, got);
        errors++;
        return;
      end
      exp_mask = pending_masks.pop_front();
      if (got !== exp_mask) begin
        $display("%0t: mask_value mismatch expected %0d actual %0d", $time, exp_mask, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [6:0] in_pix_col = 0;
  logic [6:0] in_pix_row = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] out_mask_value;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [16:0] cfg_data = 0;

  int send_idle_pct = 37;
  int recv_idle_pct = 84;
  mask_scoreboard masks = new();

  brush_mask_generator dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) masks.check_mask(out_mask_value);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [16:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    masks.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic send_pixel(logic [6:0] col, logic [6:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_pix_col <= col;
    in_pix_row <= row;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    masks.note_request(col, row);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (masks.pending_masks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_setup();
    int sel;
    sel = $urandom_range(5);
    case (sel)
      0: write_reg(CFG_BRUSH_SIZE, 17'($urandom_range(1, 16)));
      1: write_reg(CFG_BRUSH_SIZE, 17'($urandom_range(0, 255)));
      default: write_reg(CFG_BRUSH_SIZE, 17'($urandom_range(1, 64)));
    endcase
    sel = $urandom_range(4);
    write_reg(CFG_HARDNESS, sel == 0 ? 17'd65536 : sel == 1 ? 17'h1FFFF :
              17'($urandom_range(0, 65535)));
    write_reg(CFG_COS_FREQ_X, $urandom_range(3) == 0 ? 17'($urandom) :
              17'($urandom_range(0, 1023)));
    write_reg(CFG_COS_FREQ_Y, $urandom_range(3) == 0 ? 17'($urandom) :
              17'($urandom_range(0, 1023) | 32'hF000 * $urandom_range(1)));
  endtask

  initial begin
    int sz;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_pixel(0, 0);
    send_pixel(19, 20);
    send_pixel(127, 127);
    drain();
    write_reg(CFG_BRUSH_SIZE, 0);
    write_reg(CFG_HARDNESS, 65536);
    write_reg(CFG_COS_FREQ_X, 17'h08000);
    write_reg(CFG_COS_FREQ_Y, 17'h07FFF);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(127, 0);
    drain();
    write_reg(CFG_BRUSH_SIZE, 255);
    write_reg(CFG_HARDNESS, 17'h1FFFF);
    send_pixel(0, 127);
    send_pixel(64, 64);
    drain();
    write_reg(CFG_BRUSH_SIZE, 128);
    write_reg(CFG_HARDNESS, 32768);
    write_reg(CFG_COS_FREQ_X, 17'h00100);
    write_reg(CFG_COS_FREQ_Y, 17'h0FF00);
    send_pixel(0, 0);
    send_pixel(127, 127);
    send_pixel(64, 63);
    send_pixel(85, 42);
    drain();
    write_reg(8'd9, 17'h1ABCD);
    send_pixel(42, 85);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 37 : phase == 1 ? 84 : 0;
      recv_idle_pct = phase == 0 ? 84 : phase == 1 ? 37 : 0;
      for (int blk = 0; blk < 10; blk++) begin
        random_setup();
        sz = masks.size_reg == 0 ? 1 : masks.size_reg > 128 ? 128 : masks.size_reg;
        for (int i = 0; i < 61; i++) begin
          if ($urandom_range(9) == 0)
            send_pixel(7'($urandom), 7'($urandom));
          else
            send_pixel(7'($urandom_range(sz - 1)), 7'($urandom_range(sz - 1)));
        end
        drain();
      end
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (masks.errors == 0 && masks.pending_masks.size() == 0)
      $display("brush_mask_generator verification clean");
    else
      $display("brush_mask_generator verification failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("brush_mask_generator verification failed");
    $finish;
  end
endmodule
